### rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;
    localparam logic [2:0] REQ_COUNT      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [PTR_W-1:0] position;
        logic [CNT_W-1:0] fill_count;
    } t_rsp;

    // decoded command handed from front to back
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_cmd;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(DEPTH)) begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

### rtl/bounded_deque_with_search_unit.sv
// channel   valid    ready    word
// request   i_valid  o_ready  i_req (t_req: req_type, value)
// result    o_valid  i_ready  o_rsp (t_rsp: status, found, position, fill_count)
//
// Push, pop and count are done in the back end when taken; the result is registered next cycle.
// Search on n stored words reads the entry memory one word per cycle, up to the first match.
// A 2-word request queue lets requests come in while the back end searches or stalls.
// Reset (i_rst_n low, synchronous) empties the deque; memory content is not cleared.
// A held result stalls only the back end; the queue keeps accepting until full.
module bounded_deque_with_search_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bdq_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output bdq_pkg::t_rsp o_rsp
);

    logic          cmd_valid;
    logic          cmd_ready;
    bdq_pkg::t_cmd cmd;

    bdq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    bdq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule

### rtl/bdq_front.sv
module bdq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bdq_pkg::t_req i_req,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output bdq_pkg::t_cmd o_cmd
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    bdq_pkg::t_cmd     r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    bdq_pkg::t_cmd cmd_in;
    logic          push;
    logic          pop;

    always_comb begin
        cmd_in.value = i_req.value;
        case (i_req.req_type)
            bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK,
            bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK,
            bdq_pkg::REQ_SEARCH: begin
                cmd_in.op = i_req.req_type;
            end
            default: begin
                cmd_in.op = bdq_pkg::REQ_COUNT;
            end
        endcase
    end

    assign o_ready     = (r_cnt != QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/bdq_back.sv
module bdq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  bdq_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output bdq_pkg::t_rsp o_rsp
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    localparam int PTR_W = bdq_pkg::PTR_W;
    localparam int CNT_W = bdq_pkg::CNT_W;

    logic               r_state,     n_state;
    logic [CNT_W-1:0]   r_occ,       n_occ;
    logic [PTR_W-1:0]   r_front,     n_front;
    logic               r_out_valid, n_out_valid;
    bdq_pkg::t_rsp      r_rsp,       n_rsp;
    logic signed [31:0] r_key,       n_key;
    logic [CNT_W-1:0]   r_idx,       n_idx;
    logic               r_rd_vld,    n_rd_vld;
    logic [PTR_W-1:0]   r_rd_pos,    n_rd_pos;
    logic signed [31:0] r_rd_data;

    logic signed [31:0] r_mem [bdq_pkg::DEPTH];

    logic               mem_we;
    logic [PTR_W-1:0]   mem_wa;
    logic signed [31:0] mem_wd;
    logic [PTR_W-1:0]   mem_ra;
    logic               take;

    assign o_cmd_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_rsp;
    assign mem_ra      = bdq_pkg::wrap_add(r_front, r_idx[PTR_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_front     = r_front;
        n_out_valid = r_out_valid && !i_ready;
        n_rsp       = r_rsp;
        n_key       = r_key;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_pos    = r_rd_pos;
        mem_we      = 1'b0;
        mem_wa      = r_front;
        mem_wd      = i_cmd.value;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_rsp.status   = bdq_pkg::ST_OK;
                    n_rsp.found    = 1'b0;
                    n_rsp.position = '0;
                    n_out_valid    = 1'b1;
                    case (i_cmd.op)
                        bdq_pkg::REQ_PUSH_FRONT: begin
                            if (r_occ == CNT_W'(bdq_pkg::DEPTH)) begin
                                n_rsp.status = bdq_pkg::ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? PTR_W'(bdq_pkg::DEPTH - 1)
                                                          : r_front - 1'b1;
                                mem_we  = 1'b1;
                                mem_wa  = n_front;
                                n_occ   = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::REQ_PUSH_BACK: begin
                            if (r_occ == CNT_W'(bdq_pkg::DEPTH)) begin
                                n_rsp.status = bdq_pkg::ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = bdq_pkg::wrap_add(r_front, r_occ[PTR_W-1:0]);
                                n_occ  = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::REQ_POP_FRONT: begin
                            if (r_occ == '0) begin
                                n_rsp.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_front = (r_front == PTR_W'(bdq_pkg::DEPTH - 1)) ? '0
                                                                                  : r_front + 1'b1;
                                n_occ   = r_occ - 1'b1;
                            end
                        end
                        bdq_pkg::REQ_POP_BACK: begin
                            if (r_occ == '0) begin
                                n_rsp.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        bdq_pkg::REQ_SEARCH: begin
                            if (r_occ != '0) begin
                                n_out_valid = r_out_valid && !i_ready;
                                n_state     = S_SEARCH;
                                n_key       = i_cmd.value;
                                n_idx       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.fill_count = n_occ;
                end
            end
            S_SEARCH: begin
                // read stage: one entry per cycle
                if (r_idx < r_occ) begin
                    n_rd_vld = 1'b1;
                    n_rd_pos = r_idx[PTR_W-1:0];
                    n_idx    = r_idx + 1'b1;
                end
                // compare stage
                if (r_rd_vld) begin
                    if (r_rd_data == r_key) begin
                        n_state          = S_IDLE;
                        n_rd_vld         = 1'b0;
                        n_out_valid      = 1'b1;
                        n_rsp.status     = bdq_pkg::ST_OK;
                        n_rsp.found      = 1'b1;
                        n_rsp.position   = r_rd_pos;
                        n_rsp.fill_count = r_occ;
                    end else if ({1'b0, r_rd_pos} == CNT_W'(r_occ - 1'b1)) begin
                        n_state          = S_IDLE;
                        n_rd_vld         = 1'b0;
                        n_out_valid      = 1'b1;
                        n_rsp.status     = bdq_pkg::ST_OK;
                        n_rsp.found      = 1'b0;
                        n_rsp.position   = '0;
                        n_rsp.fill_count = r_occ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_rsp    <= n_rsp;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_rd_pos <= n_rd_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_front     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_front     <= n_front;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

endmodule

### tb/sv/tb_bounded_deque_with_search_unit.sv
`timescale 1ns / 100ps

module tb_bounded_deque_with_search_unit;

    import bdq_pkg::*;

    // request codes with no operation of their own; they act as a count
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_WORDS = 1400;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    class deque_scoreboard;
        logic [31:0] slot [DEPTH];
        int          head;
        int          fill;
        t_rsp        due_q [$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned hits;
        int unsigned full_drops;
        int unsigned empty_pops;

        function new();
            head = 0;
            fill = 0;
            foreach (slot[k]) slot[k] = '0;
        endfunction

        function logic [31:0] peek(input int pos);
            return slot[(head + pos) % DEPTH];
        endfunction

        function void note_request(input t_req r);
            t_rsp e;
            int   pos;
            bit   hit;
            e = '0;
            e.status = ST_OK;
            hit = 0;
            pos = 0;
            case (r.req_type)
                REQ_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slot[head] = r.value;
                        fill++;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        e.status = ST_FULL;
                    end else begin
                        slot[(head + fill) % DEPTH] = r.value;
                        fill++;
                    end
                end
                REQ_POP_FRONT: begin
                    if (fill == 0) begin
                        e.status = ST_EMPTY;
                    end else begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                REQ_POP_BACK: begin
                    if (fill == 0) begin
                        e.status = ST_EMPTY;
                    end else begin
                        fill--;
                    end
                end
                REQ_SEARCH: begin
                    for (int k = 0; k < fill; k++) begin
                        if (!hit && peek(k) == r.value) begin
                            hit = 1;
                            pos = k;
                        end
                    end
                end
                default: ;
            endcase
            if (e.status == ST_FULL) full_drops++;
            if (e.status == ST_EMPTY) empty_pops++;
            if (hit) hits++;
            e.found      = hit;
            e.position   = PTR_W'(pos);
            e.fill_count = CNT_W'(fill);
            due_q = {due_q, e};
            words_in++;
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(input t_rsp got);
            t_rsp e;
            words_out++;
            if (due_q.size() == 0) begin
                report_mismatch($sformatf("result word %0d with none expected", words_out));
            end else begin
                e = due_q[0];
                due_q.delete(0);
                if (got.status !== e.status)
                    report_mismatch($sformatf("word %0d status %0d, want %0d",
                                              words_out, got.status, e.status));
                if (got.found !== e.found)
                    report_mismatch($sformatf("word %0d found %0d, want %0d",
                                              words_out, got.found, e.found));
                if (got.position !== e.position)
                    report_mismatch($sformatf("word %0d position %0d, want %0d",
                                              words_out, got.position, e.position));
                if (got.fill_count !== e.fill_count)
                    report_mismatch($sformatf("word %0d fill_count %0d, want %0d",
                                              words_out, got.fill_count, e.fill_count));
            end
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_rsp  o_rsp;

    deque_scoreboard sb = new();

    // receiver: stall behavior changes every so often
    int       rx_mode    = 0;
    int       rx_left    = 0;
    int       rx_cyc     = 0;
    bit [7:0] stall_mask = 8'hff;

    bounded_deque_with_search_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("bounded_deque_with_search_unit regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_rsp);
        end
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode    = $urandom_range(0, 4);
            rx_left    = $urandom_range(40, 300);
            stall_mask = 8'($urandom) | 8'h01;
        end
        rx_left--;
        rx_cyc++;
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 9) < 7);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            3: i_ready <= stall_mask[3'(rx_cyc)];
            default: i_ready <= ((rx_left % 24) < 4);
        endcase
    end

    function automatic t_req word_of(input logic [2:0] req, input logic [31:0] val);
        t_req r;
        r.req_type = req;
        r.value    = val;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4, 5: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req make_word(input int mix);
        int         w;
        logic [2:0] req;
        logic [31:0] val;
        w   = $urandom_range(0, 99);
        val = pick_value();
        case (mix)
            MIX_FILL:  req = (w < 35) ? REQ_PUSH_FRONT : (w < 70) ? REQ_PUSH_BACK :
                             (w < 75) ? REQ_POP_FRONT  : (w < 80) ? REQ_POP_BACK  :
                             (w < 95) ? REQ_SEARCH     : REQ_COUNT;
            MIX_DRAIN: req = (w < 5)  ? REQ_PUSH_FRONT : (w < 10) ? REQ_PUSH_BACK :
                             (w < 40) ? REQ_POP_FRONT  : (w < 70) ? REQ_POP_BACK  :
                             (w < 90) ? REQ_SEARCH     : REQ_COUNT;
            default:   req = (w < 20) ? REQ_PUSH_FRONT : (w < 40) ? REQ_PUSH_BACK :
                             (w < 55) ? REQ_POP_FRONT  : (w < 70) ? REQ_POP_BACK  :
                             (w < 90) ? REQ_SEARCH     : REQ_COUNT;
        endcase
        if (req == REQ_COUNT) begin
            case ($urandom_range(0, 2))
                0: req = REQ_SPARE_6;
                1: req = REQ_SPARE_7;
                default: ;
            endcase
        end
        if (req == REQ_SEARCH && sb.fill > 0 && $urandom_range(0, 9) < 7) begin
            val = sb.peek($urandom_range(0, sb.fill - 1));
        end
        return word_of(req, val);
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_word(input t_req r);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.due_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int mix;
        int mix_left;
        int burst_left;
        int gap;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty-queue corner cases and unused codes
        send_word(word_of(REQ_POP_FRONT, 32'hffff_ffff));
        send_word(word_of(REQ_POP_BACK, 32'h0000_0000));
        send_word(word_of(REQ_SEARCH, 32'h0000_0000));
        send_word(word_of(REQ_COUNT, 32'h8000_0000));
        send_word(word_of(REQ_SPARE_6, 32'h7fff_ffff));
        send_word(word_of(REQ_SPARE_7, 32'h5555_aaaa));
        // last word popped at the front, then at the back
        send_word(word_of(REQ_PUSH_BACK, 32'h7fff_ffff));
        send_word(word_of(REQ_POP_FRONT, 32'h0));
        send_word(word_of(REQ_PUSH_FRONT, 32'h8000_0000));
        send_word(word_of(REQ_POP_BACK, 32'h0));
        // fill to capacity with a duplicated value
        for (int k = 0; k < DEPTH; k++) begin
            send_word(word_of((k % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                              (k == 3 || k == 10) ? 32'hffff_ffff : 32'(k * 37 - 5)));
        end
        send_word(word_of(REQ_PUSH_FRONT, 32'h1234_5678));
        send_word(word_of(REQ_PUSH_BACK, 32'h1234_5678));
        send_word(word_of(REQ_SEARCH, sb.peek(DEPTH - 1)));
        send_word(word_of(REQ_SEARCH, 32'hffff_ffff));
        send_word(word_of(REQ_SEARCH, 32'h1234_5678));
        wait_drained();

        mix        = MIX_FILL;
        mix_left   = 0;
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                wait_drained();
            end
            if (mix_left == 0) begin
                mix      = $urandom_range(MIX_FILL, MIX_EVEN);
                mix_left = $urandom_range(20, 60);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            send_word(make_word(mix));
            mix_left--;
            burst_left--;
        end
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("covered %0d request words, %0d result words checked", sb.words_in,
                 sb.words_out);
        $display("search hits %0d, pushes dropped when full %0d, pops on empty %0d",
                 sb.hits, sb.full_drops, sb.empty_pops);
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("bounded_deque_with_search_unit regression: pass");
        end else begin
            $display("bounded_deque_with_search_unit regression: fail");
        end
        $finish;
    end

endmodule
